FILE: rtl/candidate_word_enumerator_top_assert.svh
// Assertion helpers for the enumerator RTL. Each use expects clk and rst in scope.
`ifndef CANDIDATE_WORD_ENUMERATOR_TOP_ASSERT_SVH
`define CANDIDATE_WORD_ENUMERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CWE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("enumerator check failed");
`define CWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("enumerator check failed");
`else
`define CWE_ASSERT_NOW(lbl, ante, cons)
`define CWE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/cwe_pkg.sv
package cwe_pkg;

  localparam int SLOTS        = 16;
  localparam int SLOT_W       = 4;
  localparam int CHAR_W       = 8;
  localparam int POS_W        = 4;
  localparam int MINLEN_W     = 5;
  localparam int LEN_W        = 6;
  localparam int CSIZE_W      = 9;
  localparam int REV_MIN_LEN  = 4;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CSIZE    = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  localparam logic [CSIZE_W-1:0] CSIZE_RESET  = 9'd26;
  localparam logic [MINLEN_W-1:0] MINLEN_RESET = 5'd1;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } seq_state_t;

  // One digit step issued by the sequencer
  typedef struct packed {
    logic             issue;
    logic             clear;
    logic             first;
    logic             last;
    logic             stop;
    logic             tacking;
    logic [POS_W-1:0] position;
  } dig_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] digit;
    logic [POS_W-1:0]  position;
    logic              last;
  } lookup_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  position;
    logic              last;
  } result_t;

endpackage

FILE: rtl/cwe_item_if.sv
interface cwe_item_if;
  import cwe_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SLOT_W-1:0] slot;
  logic [CHAR_W-1:0] char_index;
  logic [CHAR_W-1:0] char_value;

  modport source (output valid, cmd, slot, char_index, char_value, input ready);
  modport sink (input valid, cmd, slot, char_index, char_value, output ready);
endinterface

FILE: rtl/cwe_result_if.sv
interface cwe_result_if;
  import cwe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic [POS_W-1:0]  position;
  logic              last;

  modport source (output valid, char_out, position, last, input ready);
  modport sink (input valid, char_out, position, last, output ready);
endinterface

FILE: rtl/cwe_seq.sv
`include "candidate_word_enumerator_top_assert.svh"

module cwe_seq #(
  parameter int MAX_LEN = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       item_valid,
  input  logic                                       item_cmd,
  input  logic [cwe_pkg::SLOT_W-1:0]                 item_slot,
  output logic                                       item_ready,
  input  logic                                       mode,
  input  logic [cwe_pkg::MINLEN_W-1:0]               min_length,
  input  logic                                       space,
  output cwe_pkg::dig_ctl_t                          ctl,
  output logic [$clog2(cwe_pkg::SLOTS*MAX_LEN)-1:0]  addr
);
  import cwe_pkg::*;

  localparam int DEPTH  = SLOTS * MAX_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LW     = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W:0]    MAX_LEN_C = (LEN_W + 1)'(MAX_LEN);
  localparam logic [ADDR_W-1:0] ROW       = ADDR_W'(MAX_LEN);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  seq_state_t        state, state_next;
  logic [SLOTS-1:0]  parity;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] base;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     half_r;
  logic [LW-1:0]     step;
  logic              rev_r;
  logic              tack_r;

  logic              gen_acc;
  logic [LEN_W-1:0]  len_w;
  logic              fits;
  logic              rev_w;
  logic [LW-1:0]     pos;
  logic              stop_w;
  logic              last_w;

  assign item_ready = (state == ST_IDLE);
  assign gen_acc    = item_valid && item_ready && (item_cmd == CMD_GEN);
  assign len_w      = LEN_W'(min_length) + LEN_W'(item_slot);
  assign fits       = {1'b0, len_w} <= MAX_LEN_C;
  assign rev_w      = mode && !parity[item_slot] && (len_w >= LEN_W'(REV_MIN_LEN));
  // reversed words walk from the top digit down
  assign pos        = rev_r ? (len_r - LW'(1) - step) : step;
  // even lengths stop the downward carry above the middle
  assign stop_w     = rev_r && !len_r[0] && (pos <= half_r);
  assign last_w     = (step == (len_r - LW'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      parity  <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
      if (gen_acc && fits && mode) parity[item_slot] <= ~parity[item_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (gen_acc) begin
      base   <= ADDR_W'(ADDR_W'(item_slot) * ROW);
      len_r  <= LW'(len_w);
      half_r <= LW'(len_w >> 1);
      rev_r  <= rev_w;
      tack_r <= mode;
      step   <= '0;
    end else if (ctl.issue) begin
      step <= step + LW'(1);
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    addr       = base + ADDR_W'(pos);
    case (state)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        addr      = clr_cnt;
        if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (gen_acc && fits && (len_w != '0)) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        // hold until the output queue has a place for the character
        if (space) begin
          ctl.issue    = 1'b1;
          ctl.first    = (step == '0);
          ctl.last     = last_w;
          ctl.stop     = stop_w;
          ctl.tacking  = tack_r;
          ctl.position = POS_W'(step);
          if (last_w) state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the final write-back land before the next item
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  `CWE_ASSERT_NOW(a_step_in_range, state == ST_SWEEP, step < len_r)
  `CWE_ASSERT_NEXT(a_last_ends_sweep, ctl.issue && ctl.last, state == ST_DRAIN)

endmodule

FILE: rtl/cwe_digits.sv
`include "candidate_word_enumerator_top_assert.svh"

module cwe_digits #(
  parameter int MAX_LEN = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  cwe_pkg::dig_ctl_t                          ctl,
  input  logic [$clog2(cwe_pkg::SLOTS*MAX_LEN)-1:0]  addr,
  input  logic [cwe_pkg::CSIZE_W-1:0]                size,
  output cwe_pkg::lookup_req_t                       lk
);
  import cwe_pkg::*;

  localparam int DEPTH  = SLOTS * MAX_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CHAR_W-1:0]  mem [DEPTH];
  logic [CHAR_W-1:0]  rdata;
  logic [ADDR_W-1:0]  addr1;
  dig_ctl_t           tag1;
  logic               carry;

  logic               active;
  logic               do_bump;
  logic [CSIZE_W-1:0] sum;
  logic               wrap;
  logic [CHAR_W-1:0]  bumped;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CHAR_W-1:0]  wdata;

  assign active  = tag1.first || carry;
  assign do_bump = tag1.issue && active && !tag1.stop;
  assign sum     = {1'b0, rdata} + CSIZE_W'(1);
  assign wrap    = (sum >= size);
  assign bumped  = wrap ? '0 : sum[CHAR_W-1:0];
  assign we      = ctl.clear || do_bump;
  assign waddr   = ctl.clear ? addr : addr1;
  assign wdata   = ctl.clear ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ctl.issue) begin
      rdata <= mem[addr];
      addr1 <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.issue <= 1'b0;
    end else begin
      tag1 <= ctl;
    end
  end

  // rain mode carries until a wrap, tacking mode carries through wraps
  always_ff @(posedge clk) begin
    if (tag1.issue) begin
      carry <= tag1.tacking ? (do_bump && wrap) : (do_bump && !wrap);
    end
  end

  assign lk.valid    = tag1.issue;
  assign lk.digit    = rdata;
  assign lk.position = tag1.position;
  assign lk.last     = tag1.last;

  `CWE_ASSERT_NOW(a_clear_apart_from_sweep, ctl.clear, !tag1.issue && !ctl.issue)

endmodule

FILE: rtl/cwe_charset.sv
module cwe_charset #(
  parameter int CHARSET_MAX = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [cwe_pkg::CHAR_W-1:0]  load_index,
  input  logic [cwe_pkg::CHAR_W-1:0]  load_value,
  input  cwe_pkg::lookup_req_t        lk,
  output logic                        push,
  output cwe_pkg::result_t            item
);
  import cwe_pkg::*;

  localparam int CI_W = $clog2(CHARSET_MAX);
  localparam logic [CHAR_W:0] LIM = (CHAR_W + 1)'(CHARSET_MAX);

  logic [CHAR_W-1:0] mem [CHARSET_MAX];
  logic [CHAR_W-1:0] rdata;
  logic              oob;
  logic [POS_W-1:0]  pos2;
  logic              last2;
  logic              v2;

  always_ff @(posedge clk) begin
    // drop loads beyond the table
    if (load && ({1'b0, load_index} < LIM)) mem[CI_W'(load_index)] <= load_value;
    if (lk.valid) begin
      rdata <= mem[CI_W'(lk.digit)];
      oob   <= ({1'b0, lk.digit} >= LIM);
      pos2  <= lk.position;
      last2 <= lk.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= lk.valid;
    end
  end

  assign push          = v2;
  assign item.char_out = oob ? '0 : rdata;
  assign item.position = pos2;
  assign item.last     = last2;

endmodule

FILE: rtl/cwe_out_fifo.sv
`include "candidate_word_enumerator_top_assert.svh"

module cwe_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              reserve,
  input  logic              push,
  input  cwe_pkg::result_t  push_item,
  input  logic              pop,
  output logic              valid,
  output cwe_pkg::result_t  head,
  output logic              space
);
  import cwe_pkg::*;

  result_t           q [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] resv;

  assign valid = (count != '0);
  assign head  = q[rptr];
  // a place is booked when the digit read issues, freed on the output transfer
  assign space = (resv < QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      resv  <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop) rptr <= rptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
      resv  <= resv + QCNT_W'(reserve) - QCNT_W'(pop);
    end
  end

  `CWE_ASSERT_NOW(a_push_has_room, push, count < QCNT_W'(QDEPTH))
  `CWE_ASSERT_NOW(a_booking_covers_queue, 1'b1, resv >= count)

endmodule

FILE: rtl/candidate_word_enumerator_top.sv
// Candidate word enumerator.
// items: a load (cmd 0) writes char_value into charset entry char_index.
// A generate (cmd 1) names a slot; the word of length
// min_length + slot is sent on results one character per transfer, with its
// position and last set on the final character, and the slot's digits advance.
// Words longer than MAX_LEN give no results.
// A generate holds items off while the digits of its word are swept, one
// digit read-modify-write of the digit store per character, and for the
// final write-back; a four-entry output queue sets how far the sweep runs
// ahead of the receiver.
// Reset: configuration returns to rain mode, min_length 1, charset_size 26,
// and a clearing pass zeroes the digit store, during which items is not
// ready. The charset table is not cleared.
// Stall: when results is held off the queue fills and the digit sweep pauses;
// nothing is dropped. Configuration writes go to cfg_wr_en/cfg_index/cfg_data
// and must only be made while no word is in flight.
module candidate_word_enumerator_top #(
  parameter int MAX_LEN     = 16,
  parameter int CHARSET_MAX = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cwe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwe_pkg::CFG_DATA_W-1:0]    cfg_data,
  cwe_item_if.sink                          items,
  cwe_result_if.source                      results
);
  import cwe_pkg::*;

  localparam int ADDR_W = $clog2(SLOTS * MAX_LEN);
  localparam logic [CSIZE_W-1:0] CS_LIM = CSIZE_W'(CHARSET_MAX);

  logic                mode;
  logic [MINLEN_W-1:0] min_length;
  logic [CSIZE_W-1:0]  charset_size;
  logic [CSIZE_W-1:0]  size_eff;

  logic                item_ready;
  logic                load;
  logic                space;
  dig_ctl_t            ctl;
  logic [ADDR_W-1:0]   addr;
  lookup_req_t         lk;
  logic                push;
  result_t             push_item;
  logic                pop;
  logic                q_valid;
  result_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      min_length   <= MINLEN_RESET;
      charset_size <= CSIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:    mode         <= cfg_data[0];
        CFG_MIN_LEN: min_length   <= cfg_data[MINLEN_W-1:0];
        CFG_CSIZE:   charset_size <= cfg_data[CSIZE_W-1:0];
        default:     ;
      endcase
    end
  end

  assign size_eff    = (charset_size > CS_LIM) ? CS_LIM : charset_size;
  assign items.ready = item_ready;
  assign load        = items.valid && item_ready && (items.cmd == CMD_LOAD);
  assign pop         = q_valid && results.ready;

  cwe_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_cmd   (items.cmd),
    .item_slot  (items.slot),
    .item_ready (item_ready),
    .mode       (mode),
    .min_length (min_length),
    .space      (space),
    .ctl        (ctl),
    .addr       (addr)
  );

  cwe_digits #(
    .MAX_LEN (MAX_LEN)
  ) u_digits (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .addr (addr),
    .size (size_eff),
    .lk   (lk)
  );

  cwe_charset #(
    .CHARSET_MAX (CHARSET_MAX)
  ) u_charset (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_index (items.char_index),
    .load_value (items.char_value),
    .lk         (lk),
    .push       (push),
    .item       (push_item)
  );

  cwe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (ctl.issue),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head),
    .space     (space)
  );

  assign results.valid    = q_valid;
  assign results.char_out = head.char_out;
  assign results.position = head.position;
  assign results.last     = head.last;

endmodule

FILE: tb/tb_candidate_word_enumerator_top.sv
`timescale 1ns / 1ps

module tb_candidate_word_enumerator_top;
  import cwe_pkg::*;

  localparam int MAX_LEN       = 16;
  localparam int CHARSET_MAX   = 256;
  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_ITEMS  = 350;
  localparam int PHASES        = 7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cwe_item_if   items ();
  cwe_result_if results ();

  candidate_word_enumerator_top #(
    .MAX_LEN     (MAX_LEN),
    .CHARSET_MAX (CHARSET_MAX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  always #2 clk = ~clk;

  // Shadow of the block: charset, per-slot digits and parity, configuration
  logic [CHAR_W-1:0]   charset [CHARSET_MAX];
  bit                  written [CHARSET_MAX];
  logic [CHAR_W-1:0]   digits [SLOTS][MAX_LEN];
  bit                  parity [SLOTS];
  bit                  m_mode;
  logic [MINLEN_W-1:0] m_min_len;
  logic [CSIZE_W-1:0]  m_csize;

  result_t expected_chars[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      steady = 1'b0;

  function automatic bit bump_digit(inout logic [CHAR_W-1:0] d, input int size);
    int v;
    v = int'(d) + 1;
    if (v >= size) begin
      d = '0;
      return 1'b1;
    end
    d = CHAR_W'(v);
    return 1'b0;
  endfunction

  // A load sets a charset entry; a generate queues its word and steps the digits
  function automatic void enumerate_step(logic cmd, logic [SLOT_W-1:0] slot,
                                         logic [CHAR_W-1:0] idx,
                                         logic [CHAR_W-1:0] val);
    int                len;
    int                size;
    int                p;
    bit                rev;
    logic [CHAR_W-1:0] d;
    result_t           r;
    if (cmd == CMD_LOAD) begin
      charset[idx] = val;
      written[idx] = 1'b1;
      return;
    end
    len = int'(m_min_len) + int'(slot);
    if (len > MAX_LEN) return;
    size = (m_csize > CHARSET_MAX) ? CHARSET_MAX : int'(m_csize);
    rev  = m_mode && !parity[slot] && len >= REV_MIN_LEN;
    for (int i = 0; i < len; i++) begin
      d = rev ? digits[slot][len - 1 - i] : digits[slot][i];
      r.char_out = charset[d];
      r.position = POS_W'(i);
      r.last     = (i == len - 1);
      expected_chars.push_back(r);
    end
    if (!m_mode) begin
      // bump upward, stop after the first wrap
      for (int i = 0; i < len; i++)
        if (bump_digit(digits[slot][i], size)) break;
    end else begin
      if (!rev) begin
        for (int i = 0; i < len; i++)
          if (!bump_digit(digits[slot][i], size)) break;
      end else begin
        // carry from the top digit down; even lengths stop above the middle
        p = len;
        while (p > 0) begin
          if (len % 2 == 0 && p - 1 <= len / 2) break;
          if (!bump_digit(digits[slot][p - 1], size)) break;
          p--;
        end
      end
      parity[slot] = !parity[slot];
    end
  endfunction

  task automatic send_item(logic cmd, logic [SLOT_W-1:0] slot,
                           logic [CHAR_W-1:0] idx, logic [CHAR_W-1:0] val);
    if (!steady)
      while ($urandom_range(99) < IDLE_PCT) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    items.valid      <= 1'b1;
    items.cmd        <= cmd;
    items.slot       <= slot;
    items.char_index <= idx;
    items.char_value <= val;
    do @(posedge clk); while (!items.ready);
    enumerate_step(cmd, slot, idx, val);
  endtask

  // Load any charset entry the word would read before it is written, then generate
  task automatic request_word(logic [SLOT_W-1:0] slot);
    int len;
    len = int'(m_min_len) + int'(slot);
    if (len <= MAX_LEN)
      for (int i = 0; i < len; i++)
        if (!written[digits[slot][i]])
          send_item(CMD_LOAD, SLOT_W'($urandom), digits[slot][i], CHAR_W'($urandom));
    send_item(CMD_GEN, slot, CHAR_W'($urandom), CHAR_W'($urandom));
  endtask

  task automatic wait_words_out();
    items.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    // a trailing load or empty word may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_words_out();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_MODE:    m_mode = data[0];
      CFG_MIN_LEN: m_min_len = data[MINLEN_W-1:0];
      CFG_CSIZE:   m_csize = data[CSIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int mode, int min_len, int csize);
    write_register(CFG_MODE, CFG_DATA_W'(mode));
    write_register(CFG_MIN_LEN, CFG_DATA_W'(min_len));
    write_register(CFG_CSIZE, CFG_DATA_W'(csize));
  endtask

  task automatic test_directed_rain();
    configure(0, 1, 3);
    send_item(CMD_LOAD, 4'h0, 8'h00, 8'hFF);
    send_item(CMD_LOAD, 4'hF, 8'h01, 8'h00);
    send_item(CMD_LOAD, 4'h5, 8'h02, 8'hA5);
    send_item(CMD_LOAD, 4'hA, 8'hFF, 8'h5A);
    repeat (3) request_word(4'd0);
    repeat (2) request_word(4'd2);
  endtask

  task automatic test_word_lengths();
    write_register(CFG_MIN_LEN, CFG_DATA_W'(16));
    request_word(4'd0);
    request_word(4'd15);
    request_word(4'd1);
    write_register(CFG_MIN_LEN, CFG_DATA_W'(0));
    request_word(4'd0);
    write_register(CFG_MODE, CFG_DATA_W'(1));
    request_word(4'd0);
    write_register(CFG_MIN_LEN, CFG_DATA_W'(31));
    request_word(4'd15);
  endtask

  task automatic test_charset_size();
    configure(0, 1, 0);
    request_word(4'd0);
    request_word(4'd3);
    write_register(CFG_CSIZE, CFG_DATA_W'(4));
    repeat (3) request_word(4'd0);
    // shrink below the digit just reached
    write_register(CFG_CSIZE, CFG_DATA_W'(2));
    request_word(4'd0);
    write_register(CFG_CSIZE, CFG_DATA_W'(511));
    request_word(4'd1);
  endtask

  task automatic test_tacking();
    configure(1, 4, 2);
    repeat (3) request_word(4'd0);
    repeat (2) request_word(4'd1);
    write_register(CFG_MIN_LEN, CFG_DATA_W'(1));
    request_word(4'd2);
  endtask

  task automatic test_random_phases();
    int                ml;
    int                cs;
    int                hi;
    logic [CHAR_W-1:0] idx;
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 2);
      case ($urandom_range(9))
        0:       ml = 0;
        1:       ml = 16;
        2:       ml = $urandom_range(31);
        default: ml = $urandom_range(1, 8);
      endcase
      case (ph)
        1:       cs = 256;
        3:       cs = 511;
        4:       cs = 0;
        5:       cs = 1;
        default: cs = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(2, 12);
      endcase
      configure($urandom_range(1), ml, cs);
      hi = (ml <= MAX_LEN) ? MAX_LEN - ml : 0;
      if (hi > SLOTS - 1) hi = SLOTS - 1;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if ($urandom_range(99) < 25) begin
          idx = ($urandom_range(3) == 0) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(15));
          send_item(CMD_LOAD, SLOT_W'($urandom), idx, CHAR_W'($urandom));
        end else if ($urandom_range(9) != 0) begin
          request_word(SLOT_W'($urandom_range(hi)));
        end else begin
          request_word(SLOT_W'($urandom));
        end
        // hold the sender until every character has come out
        if ((ph == 0 && n == 25) || $urandom_range(99) == 0) wait_words_out();
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) results.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : check_chars
    result_t want;
    if (!rst && results.valid && results.ready) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character: char %h position %0d last %b",
                   results.char_out, results.position, results.last);
      end else begin
        want = expected_chars.pop_front();
        if (results.char_out !== want.char_out || results.position !== want.position ||
            results.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("character mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     want.char_out, want.position, want.last,
                     results.char_out, results.position, results.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_candidate_word_enumerator_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    items.valid      = 1'b0;
    items.cmd        = CMD_LOAD;
    items.slot       = '0;
    items.char_index = '0;
    items.char_value = '0;
    results.ready    = 1'b0;
    m_mode           = 1'b0;
    m_min_len        = MINLEN_RESET;
    m_csize          = CSIZE_RESET;
    for (int i = 0; i < CHARSET_MAX; i++) begin
      charset[i] = '0;
      written[i] = 1'b0;
    end
    for (int s = 0; s < SLOTS; s++) begin
      parity[s] = 1'b0;
      for (int i = 0; i < MAX_LEN; i++) digits[s][i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_rain();
    test_word_lengths();
    test_charset_size();
    test_tacking();
    test_random_phases();
    wait_words_out();
    if (mismatches == 0) begin
      $display("tb_candidate_word_enumerator_top OK");
    end else begin
      $display("tb_candidate_word_enumerator_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cwe_pkg.sv
rtl/cwe_item_if.sv
rtl/cwe_result_if.sv
rtl/cwe_seq.sv
rtl/cwe_digits.sv
rtl/cwe_charset.sv
rtl/cwe_out_fifo.sv
rtl/candidate_word_enumerator_top.sv
tb/tb_candidate_word_enumerator_top.sv
